[hw/rtl/assert_macros.svh]
// Assertion macros shared by the RTL.
// Clocked implication checks; they compile away under SYNTHESIS.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define AST_IMPLY(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// next-cycle implication
`define AST_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define AST_IMPLY(lbl, clk, rst, ante, cons, msg)
`define AST_NEXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

[hw/rtl/pidsp_pkg.sv]
// Package for the PID speed loop: constants, speed table, datapath op codes,
// controller command and status structs. No dependencies.
`default_nettype none
package pidsp_pkg;

  localparam int TABLE_DEPTH = 256;
  localparam int DEPTH_USED  = (TABLE_DEPTH < 256) ? TABLE_DEPTH : 256;
  localparam logic [7:0] SP_MAX   = 8'(DEPTH_USED - 1);
  localparam logic [7:0] SP_RESET = 8'd127;
  localparam int unsigned SCALE = 100;

  // x / 100 == (x * DIV_RECIP) >> DIV_SHIFT for every 32-bit unsigned x
  localparam logic [31:0] DIV_RECIP = 32'h51EB851F;
  localparam int          DIV_SHIFT = 37;

  localparam logic [5:0] STEP_FINE   = 6'd1;
  localparam logic [5:0] STEP_MID    = 6'd5;
  localparam logic [5:0] STEP_COARSE = 6'd10;

  localparam logic [1:0] REG_PROP  = 2'd0;
  localparam logic [1:0] REG_INTEG = 2'd1;
  localparam logic [1:0] REG_DERIV = 2'd2;

  localparam logic [1:0] ENC_NONE  = 2'b00;
  localparam logic [1:0] ENC_UP    = 2'b01;
  localparam logic [1:0] ENC_DOWN2 = 2'b10;
  localparam logic [1:0] ENC_DOWN  = 2'b11;

  localparam logic [9:0] SPEED_TABLE [0:255] = '{
    10'd0, 10'd16, 10'd45, 10'd68, 10'd87, 10'd104, 10'd119, 10'd133, 10'd146, 10'd158,
    10'd169, 10'd180, 10'd191, 10'd201, 10'd210, 10'd220, 10'd229, 10'd237, 10'd246,
    10'd254, 10'd262, 10'd270, 10'd277, 10'd285, 10'd292, 10'd299, 10'd306, 10'd313,
    10'd320, 10'd327, 10'd333, 10'd340, 10'd346, 10'd352, 10'd358, 10'd364, 10'd370,
    10'd376, 10'd382, 10'd388, 10'd393, 10'd399, 10'd404, 10'd410, 10'd415, 10'd421,
    10'd426, 10'd431, 10'd436, 10'd441, 10'd446, 10'd451, 10'd456, 10'd461, 10'd466,
    10'd471, 10'd475, 10'd480, 10'd485, 10'd490, 10'd494, 10'd499, 10'd503, 10'd508,
    10'd512, 10'd517, 10'd521, 10'd525, 10'd530, 10'd534, 10'd538, 10'd542, 10'd547,
    10'd551, 10'd555, 10'd559, 10'd563, 10'd567, 10'd571, 10'd575, 10'd579, 10'd583,
    10'd587, 10'd591, 10'd595, 10'd599, 10'd602, 10'd606, 10'd610, 10'd614, 10'd618,
    10'd621, 10'd625, 10'd629, 10'd632, 10'd636, 10'd640, 10'd643, 10'd647, 10'd650,
    10'd654, 10'd657, 10'd661, 10'd664, 10'd668, 10'd671, 10'd675, 10'd678, 10'd682,
    10'd685, 10'd688, 10'd692, 10'd695, 10'd699, 10'd702, 10'd705, 10'd708, 10'd712,
    10'd715, 10'd718, 10'd722, 10'd725, 10'd728, 10'd731, 10'd734, 10'd738, 10'd741,
    10'd744, 10'd747, 10'd750, 10'd753, 10'd756, 10'd759, 10'd763, 10'd766, 10'd769,
    10'd772, 10'd775, 10'd778, 10'd781, 10'd784, 10'd787, 10'd790, 10'd793, 10'd796,
    10'd799, 10'd802, 10'd804, 10'd807, 10'd810, 10'd813, 10'd816, 10'd819, 10'd822,
    10'd825, 10'd828, 10'd830, 10'd833, 10'd836, 10'd839, 10'd842, 10'd839, 10'd841,
    10'd843, 10'd845, 10'd847, 10'd849, 10'd851, 10'd853, 10'd855, 10'd857, 10'd859,
    10'd861, 10'd863, 10'd865, 10'd867, 10'd869, 10'd871, 10'd873, 10'd875, 10'd877,
    10'd879, 10'd881, 10'd883, 10'd885, 10'd887, 10'd889, 10'd891, 10'd893, 10'd895,
    10'd896, 10'd898, 10'd900, 10'd902, 10'd904, 10'd906, 10'd908, 10'd910, 10'd912,
    10'd913, 10'd915, 10'd917, 10'd919, 10'd921, 10'd923, 10'd925, 10'd926, 10'd928,
    10'd930, 10'd932, 10'd934, 10'd936, 10'd937, 10'd939, 10'd941, 10'd943, 10'd945,
    10'd946, 10'd948, 10'd950, 10'd952, 10'd954, 10'd955, 10'd957, 10'd959, 10'd961,
    10'd962, 10'd964, 10'd966, 10'd968, 10'd969, 10'd971, 10'd973, 10'd975, 10'd976,
    10'd978, 10'd980, 10'd981, 10'd983, 10'd985, 10'd986, 10'd988, 10'd990, 10'd992,
    10'd993, 10'd995, 10'd997, 10'd998, 10'd1000, 10'd1002, 10'd1003, 10'd1005, 10'd1007,
    10'd1008, 10'd1010, 10'd1012
  };

  typedef enum logic [3:0] {
    OP_NONE, OP_LOOKUP, OP_ERR, OP_SUM, OP_DIVS, OP_INTEG, OP_MP, OP_MI, OP_MD,
    OP_ACC, OP_TOT, OP_DIVU, OP_CUR, OP_SSTEP, OP_FINISH
  } dp_op_t;

  typedef struct packed {
    logic   load;
    dp_op_t op;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic hit;
    logic out_block;
  } sts_t;

endpackage
`default_nettype wire

[hw/rtl/pidsp_div.sv]
// Divide-by-100 unit by reciprocal multiplication: magnitude, then product;
// done rises with it. Signed mode truncates toward zero. Uses pidsp_pkg.
`default_nettype none
module pidsp_div (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic        sgn,
  input  wire logic [31:0] dividend,
  output logic             done,
  output logic [31:0]      quot
);

  logic        armed;
  logic        neg;
  logic [31:0] mag;
  logic [63:0] prod;
  logic [31:0] q;

  assign q    = 32'(prod >> pidsp_pkg::DIV_SHIFT);
  assign quot = neg ? (32'd0 - q) : q;

  always_ff @(posedge clk) begin
    if (rst) begin
      armed <= 1'b0;
      done  <= 1'b0;
    end else begin
      armed <= start;
      done  <= armed;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg <= sgn & dividend[31];
      mag <= (sgn & dividend[31]) ? (32'd0 - dividend) : dividend;
    end
    if (armed) prod <= 64'(mag) * 64'(pidsp_pkg::DIV_RECIP);
  end

endmodule
`default_nettype wire

[hw/rtl/pidsp_dp.sv]
// Datapath: setpoint/direction state, PID arithmetic, table search, output regs.
// Uses pidsp_pkg and pidsp_div.
`default_nettype none
module pidsp_dp (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire pidsp_pkg::cmd_t   cmd,
  output pidsp_pkg::sts_t        sts,
  input  wire logic [7:0]        prop_gain,
  input  wire logic [7:0]        integ_gain,
  input  wire logic [7:0]        deriv_gain,
  input  wire logic [1:0]        encoder_step,
  input  wire logic [1:0]        step_select,
  input  wire logic              stop_request,
  input  wire logic              push_switch,
  input  wire logic [15:0]       measured_speed,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [7:0]             duty_out,
  output logic [7:0]             setpoint_out,
  output logic [9:0]             target_speed,
  output logic                   direction_out,
  output logic                   direction_changed
);

  logic [7:0]  setpoint;
  logic [31:0] integral_acc;
  logic [31:0] previous_error;
  logic        last_push_switch;
  logic        direction;
  logic        changed;
  logic        stop;
  logic [15:0] meas;
  logic [9:0]  target_raw;
  logic [16:0] tgt_s;
  logic [22:0] read_s;
  logic [31:0] err, sum, integ, deriv, prod, corr, current;
  logic [7:0]  idx;
  logic [7:0]  duty;

  logic [5:0]        mstep;
  logic signed [5:0] delta;
  logic signed [9:0] sp_sum;
  logic [7:0]        sp_new;
  logic [7:0]        mul_gain;
  logic [31:0]       mul_opd;
  logic [39:0]       mul_full;
  logic              div_start;
  logic              div_sgn;
  logic              div_done;
  logic [31:0]       div_q;
  logic              hit;

  always_comb begin
    if (step_select == 2'b00) mstep = pidsp_pkg::STEP_FINE;
    else if (step_select[1]) mstep = pidsp_pkg::STEP_COARSE;
    else mstep = pidsp_pkg::STEP_MID;
    unique case (encoder_step)
      pidsp_pkg::ENC_UP:    delta = $signed(mstep);
      pidsp_pkg::ENC_DOWN:  delta = -$signed(mstep);
      pidsp_pkg::ENC_DOWN2: delta = -$signed({mstep[4:0], 1'b0});
      default:              delta = 6'sd0;
    endcase
    sp_sum = $signed({2'b00, setpoint}) + $signed({{4{delta[5]}}, delta});
    if (sp_sum < 10'sd0) sp_new = 8'd0;
    else if (sp_sum > $signed({2'b00, pidsp_pkg::SP_MAX})) sp_new = pidsp_pkg::SP_MAX;
    else sp_new = sp_sum[7:0];
  end

  always_comb begin
    unique case (cmd.op)
      pidsp_pkg::OP_MI: begin
        mul_gain = integ_gain;
        mul_opd  = integ;
      end
      pidsp_pkg::OP_MD: begin
        mul_gain = deriv_gain;
        mul_opd  = deriv;
      end
      default: begin
        mul_gain = prop_gain;
        mul_opd  = err;
      end
    endcase
  end
  assign mul_full = 40'(mul_gain) * 40'(mul_opd);

  assign hit       = (current >= 32'(pidsp_pkg::SPEED_TABLE[idx]));
  assign div_start = (cmd.op == pidsp_pkg::OP_DIVS) || (cmd.op == pidsp_pkg::OP_DIVU);
  assign div_sgn   = (cmd.op == pidsp_pkg::OP_DIVS);

  pidsp_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .sgn      (div_sgn),
    .dividend (sum),
    .done     (div_done),
    .quot     (div_q)
  );

  assign sts.div_done  = div_done;
  assign sts.hit       = hit;
  assign sts.out_block = out_valid & out_stall;

  // architectural state
  always_ff @(posedge clk) begin
    if (rst) begin
      setpoint         <= pidsp_pkg::SP_RESET;
      integral_acc     <= 32'd0;
      previous_error   <= 32'd0;
      last_push_switch <= 1'b0;
      direction        <= 1'b0;
      out_valid        <= 1'b0;
    end else begin
      if (cmd.load) begin
        setpoint         <= sp_new;
        last_push_switch <= push_switch;
        if (push_switch != last_push_switch) direction <= ~direction;
      end
      if (cmd.op == pidsp_pkg::OP_FINISH) begin
        integral_acc   <= integ;
        previous_error <= err;
        if (stop) setpoint <= 8'd0;
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      meas    <= measured_speed;
      stop    <= stop_request;
      changed <= (push_switch != last_push_switch);
    end
    unique case (cmd.op)
      pidsp_pkg::OP_LOOKUP: begin
        target_raw <= pidsp_pkg::SPEED_TABLE[setpoint];
        tgt_s      <= 17'(pidsp_pkg::SPEED_TABLE[setpoint]) * 17'(pidsp_pkg::SCALE);
        read_s     <= 23'(meas) * 23'(pidsp_pkg::SCALE);
      end
      pidsp_pkg::OP_ERR:   err   <= 32'(tgt_s) - 32'(read_s);
      pidsp_pkg::OP_SUM:   sum   <= integral_acc + err;
      pidsp_pkg::OP_INTEG: integ <= div_q;
      pidsp_pkg::OP_MP:    prod  <= mul_full[31:0];
      pidsp_pkg::OP_MI: begin
        corr  <= prod;
        prod  <= mul_full[31:0];
        deriv <= err - previous_error;
      end
      pidsp_pkg::OP_MD: begin
        corr <= corr + prod;
        prod <= mul_full[31:0];
      end
      pidsp_pkg::OP_ACC: corr <= corr + prod;
      pidsp_pkg::OP_TOT: sum  <= 32'(tgt_s) + corr;
      pidsp_pkg::OP_CUR: begin
        current <= div_q;
        idx     <= pidsp_pkg::SP_MAX;
      end
      pidsp_pkg::OP_SSTEP: begin
        // entry 0 is zero, so the walk always stops
        if (hit) duty <= idx;
        else idx <= idx - 8'd1;
      end
      pidsp_pkg::OP_FINISH: begin
        duty_out          <= duty;
        setpoint_out      <= setpoint;
        target_speed      <= target_raw;
        direction_out     <= direction;
        direction_changed <= changed;
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

[hw/rtl/pidsp_ctrl.sv]
// Controller FSM: sequences one control tick through the datapath.
// Uses pidsp_pkg command/status structs.
`default_nettype none
module pidsp_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_stall,
  output pidsp_pkg::cmd_t      cmd,
  input  wire pidsp_pkg::sts_t sts
);

  typedef enum logic [15:0] {
    S_IDLE   = 16'h0001,
    S_LOOKUP = 16'h0002,
    S_ERR    = 16'h0004,
    S_SUM    = 16'h0008,
    S_DIVS   = 16'h0010,
    S_WAITS  = 16'h0020,
    S_MP     = 16'h0040,
    S_MI     = 16'h0080,
    S_MD     = 16'h0100,
    S_ACC    = 16'h0200,
    S_TOT    = 16'h0400,
    S_DIVU   = 16'h0800,
    S_WAITU  = 16'h1000,
    S_SEARCH = 16'h2000,
    S_FINISH = 16'h4000,
    S_SPARE  = 16'h8000
  } state_t;

  state_t state, state_next;

  assign in_stall = (state != S_IDLE);

  always_comb begin
    state_next = state;
    cmd.load   = 1'b0;
    cmd.op     = pidsp_pkg::OP_NONE;
    unique case (state)
      S_IDLE: if (in_valid) begin
        cmd.load   = 1'b1;
        state_next = S_LOOKUP;
      end
      S_LOOKUP: begin
        cmd.op     = pidsp_pkg::OP_LOOKUP;
        state_next = S_ERR;
      end
      S_ERR: begin
        cmd.op     = pidsp_pkg::OP_ERR;
        state_next = S_SUM;
      end
      S_SUM: begin
        cmd.op     = pidsp_pkg::OP_SUM;
        state_next = S_DIVS;
      end
      S_DIVS: begin
        cmd.op     = pidsp_pkg::OP_DIVS;
        state_next = S_WAITS;
      end
      S_WAITS: if (sts.div_done) begin
        cmd.op     = pidsp_pkg::OP_INTEG;
        state_next = S_MP;
      end
      S_MP: begin
        cmd.op     = pidsp_pkg::OP_MP;
        state_next = S_MI;
      end
      S_MI: begin
        cmd.op     = pidsp_pkg::OP_MI;
        state_next = S_MD;
      end
      S_MD: begin
        cmd.op     = pidsp_pkg::OP_MD;
        state_next = S_ACC;
      end
      S_ACC: begin
        cmd.op     = pidsp_pkg::OP_ACC;
        state_next = S_TOT;
      end
      S_TOT: begin
        cmd.op     = pidsp_pkg::OP_TOT;
        state_next = S_DIVU;
      end
      S_DIVU: begin
        cmd.op     = pidsp_pkg::OP_DIVU;
        state_next = S_WAITU;
      end
      S_WAITU: if (sts.div_done) begin
        cmd.op     = pidsp_pkg::OP_CUR;
        state_next = S_SEARCH;
      end
      S_SEARCH: begin
        cmd.op = pidsp_pkg::OP_SSTEP;
        if (sts.hit) state_next = S_FINISH;
      end
      S_FINISH: if (!sts.out_block) begin
        cmd.op     = pidsp_pkg::OP_FINISH;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

endmodule
`default_nettype wire

[hw/rtl/pid_speed_loop_with_rpm_table.sv]
// PID speed loop top level: gain registers, controller and datapath.
// Depends on pidsp_pkg, pidsp_ctrl, pidsp_dp, assert_macros.svh.
//
// Usage: one input transfer per control tick (in_valid/in_stall) carries the
// encoder step, step select, stop request, push-switch level and measured
// speed. Each tick yields exactly one result transfer (out_valid/out_stall)
// with duty, setpoint, target speed and direction flags.
// The time from input transfer to result is set mostly by the reverse table
// walk, which tests one entry per cycle from the top index down to the first
// match; the rest is PID sequencing with two divide-by-100 steps, and the
// result waits for a stalled output register to be freed.
// One tick is processed at a time; in_stall is high from the input transfer
// until the result is moved into the output register.
// The output register holds a result while the receiver stalls; the next tick
// is accepted and computed meanwhile, and waits before its result is written.
// Gains are written on the cfg port (index 0 prop, 1 integ, 2 deriv; others
// ignored), always ready; the user must write only while idle (unchecked).
// Reset (rst, synchronous) sets setpoint 127, integral and previous error 0,
// direction and switch history 0, gains 1/1/0, and empties the output.
`default_nettype none
`include "assert_macros.svh"
module pid_speed_loop_with_rpm_table (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  encoder_step,
  input  wire logic [1:0]  step_select,
  input  wire logic        stop_request,
  input  wire logic        push_switch,
  input  wire logic [15:0] measured_speed,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       duty_out,
  output logic [7:0]       setpoint_out,
  output logic [9:0]       target_speed,
  output logic             direction_out,
  output logic             direction_changed,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [7:0]  cfg_data
);

  logic [7:0]      prop_gain, integ_gain, deriv_gain;
  pidsp_pkg::cmd_t cmd;
  pidsp_pkg::sts_t sts;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      prop_gain  <= 8'd1;
      integ_gain <= 8'd1;
      deriv_gain <= 8'd0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        pidsp_pkg::REG_PROP:  prop_gain  <= cfg_data;
        pidsp_pkg::REG_INTEG: integ_gain <= cfg_data;
        pidsp_pkg::REG_DERIV: deriv_gain <= cfg_data;
        default: ;
      endcase
    end
  end

  pidsp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .cmd      (cmd),
    .sts      (sts)
  );

  pidsp_dp u_dp (
    .clk               (clk),
    .rst               (rst),
    .cmd               (cmd),
    .sts               (sts),
    .prop_gain         (prop_gain),
    .integ_gain        (integ_gain),
    .deriv_gain        (deriv_gain),
    .encoder_step      (encoder_step),
    .step_select       (step_select),
    .stop_request      (stop_request),
    .push_switch       (push_switch),
    .measured_speed    (measured_speed),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .duty_out          (duty_out),
    .setpoint_out      (setpoint_out),
    .target_speed      (target_speed),
    .direction_out     (direction_out),
    .direction_changed (direction_changed)
  );

  `AST_NEXT(a_busy_after_accept, clk, rst, in_valid && !in_stall, in_stall, "no stall after input transfer")
  `AST_IMPLY(a_sp_in_range, clk, rst, out_valid, setpoint_out <= pidsp_pkg::SP_MAX, "setpoint out of range")
  `AST_NEXT(a_finish_loads_out, clk, rst, cmd.op == pidsp_pkg::OP_FINISH, out_valid, "finished result not shown")
  `AST_IMPLY(a_no_finish_blocked, clk, rst, out_valid && out_stall, cmd.op != pidsp_pkg::OP_FINISH, "result overwritten")

endmodule
`default_nettype wire

[tb/pid_speed_loop_with_rpm_table_tb.sv]
// Self-checking bench for the PID speed loop: directed table, then random ticks,
// each result compared against a local model of the loop. Depends on pidsp_pkg and pid_speed_loop_with_rpm_table.
`default_nettype none
module pid_speed_loop_with_rpm_table_tb;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk = 1'b0, rst = 1'b1;
  logic in_valid = 1'b0, out_stall = 1'b0, cfg_valid = 1'b0;
  logic in_stall, out_valid, cfg_ready;
  logic [1:0] encoder_step = pidsp_pkg::ENC_NONE, step_select = '0;
  logic [1:0] cfg_index = pidsp_pkg::REG_PROP;
  logic stop_request = 1'b0, push_switch = 1'b0;
  logic [15:0] measured_speed = '0;
  logic [7:0] cfg_data = '0;
  logic [7:0] duty_out, setpoint_out;
  logic [9:0] target_speed;
  logic direction_out, direction_changed;

  pid_speed_loop_with_rpm_table i_dut (.*);

  typedef struct packed {
    logic [1:0] enc;
    logic [1:0] sel;
    logic stop;
    logic push;
    logic [15:0] meas;
  } tick_t;

  typedef struct packed {
    logic [7:0] duty;
    logic [7:0] sp;
    logic [9:0] tgt;
    logic dir;
    logic chg;
  } loop_out_t;

  typedef struct {
    tick_t t;
    bit known;
    loop_out_t res;
  } row_t;

  // loop state mirror
  logic [7:0] m_kp, m_ki, m_kd, m_sp;
  logic [31:0] m_integ, m_prev_err;
  logic m_last_push, m_dir;
  loop_out_t duty_q[$];
  int errors = 0;
  int idle_cycles = 0;
  int stall_left = 0;
  bit quiet = 1'b0;
  bit hold_off = 1'b0;

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic logic [31:0] div100_trunc(logic [31:0] v);
    if (v[31]) return 32'd0 - ((32'd0 - v) / pidsp_pkg::SCALE);
    return v / pidsp_pkg::SCALE;
  endfunction

  function automatic loop_out_t loop_tick(tick_t t);
    loop_out_t r;
    int step, mult, sp;
    logic [31:0] tgt, rd, err, integ, deriv, corr, cur;
    r.chg = (t.push != m_last_push);
    if (r.chg) m_dir = ~m_dir;
    m_last_push = t.push;
    step = $signed(t.enc);
    mult = (t.sel == 2'd0) ? 1 : (t.sel[1] ? 10 : 5);
    sp = int'(m_sp) + mult * step;
    if (sp < 0) sp = 0;
    if (sp > int'(pidsp_pkg::SP_MAX)) sp = int'(pidsp_pkg::SP_MAX);
    m_sp = sp[7:0];
    rd = pidsp_pkg::SCALE * 32'(t.meas);
    tgt = pidsp_pkg::SCALE * 32'(pidsp_pkg::SPEED_TABLE[m_sp]);
    err = tgt - rd;
    integ = div100_trunc(m_integ + err);
    deriv = err - m_prev_err;
    corr = 32'(m_kp) * err + 32'(m_ki) * integ + 32'(m_kd) * deriv;
    cur = (tgt + corr) / pidsp_pkg::SCALE;
    r.duty = '0;
    for (int i = pidsp_pkg::DEPTH_USED - 1; i >= 0; i--) begin
      if (cur >= 32'(pidsp_pkg::SPEED_TABLE[i])) begin
        r.duty = i[7:0];
        break;
      end
    end
    r.sp = m_sp;
    r.tgt = pidsp_pkg::SPEED_TABLE[m_sp];
    r.dir = m_dir;
    m_integ = integ;
    m_prev_err = err;
    if (t.stop) m_sp = '0;
    return r;
  endfunction

  task automatic write_gain(logic [1:0] idx, logic [7:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      pidsp_pkg::REG_PROP: m_kp = val;
      pidsp_pkg::REG_INTEG: m_ki = val;
      pidsp_pkg::REG_DERIV: m_kd = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    while (duty_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // send one tick; the expectation is queued when the transfer is seen
  task automatic send_tick(tick_t t, bit gaps);
    if (gaps && !quiet && $urandom_range(0, 3) == 0) repeat ($urandom_range(1, 18)) @(negedge clk);
    @(negedge clk);
    in_valid <= 1'b1;
    {encoder_step, step_select, stop_request, push_switch, measured_speed} <= t;
    do @(posedge clk); while (in_stall);
    duty_q.push_back(loop_tick(t));
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  function automatic tick_t rand_tick();
    tick_t t;
    t.enc = ($urandom_range(0, 19) == 0) ? pidsp_pkg::ENC_DOWN2 : 2'($urandom_range(0, 3));
    t.sel = 2'($urandom);
    t.stop = ($urandom_range(0, 15) == 0);
    t.push = ($urandom_range(0, 7) == 0) ? ~m_last_push : m_last_push;
    case ($urandom_range(0, 3))
      0: t.meas = 16'($urandom);
      1: t.meas = 16'($urandom_range(0, 1023));
      default: t.meas = 16'(int'(pidsp_pkg::SPEED_TABLE[m_sp]) + $urandom_range(0, 40) - 20);
    endcase
    return t;
  endfunction

  // result side: random stall bursts, one long hold-off on request
  always @(negedge clk) begin
    if (hold_off) out_stall <= 1'b1;
    else if (quiet) out_stall <= 1'b0;
    else if (stall_left != 0) begin
      stall_left = stall_left - 1;
      out_stall <= (stall_left != 0);
    end else if ($urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(1, 18);
      out_stall <= 1'b1;
    end else out_stall <= 1'b0;
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      loop_out_t got, want;
      got = '{duty_out, setpoint_out, target_speed, direction_out, direction_changed};
      if (duty_q.size() == 0) begin
        $display("%0t: unexpected result %p", $time, got);
        errors++;
      end else begin
        want = duty_q.pop_front();
        if (got.duty !== want.duty)
          $display("%0t: duty_out exp %0d got %0d", $time, want.duty, got.duty);
        if (got.sp !== want.sp)
          $display("%0t: setpoint_out exp %0d got %0d", $time, want.sp, got.sp);
        if (got.tgt !== want.tgt)
          $display("%0t: target_speed exp %0d got %0d", $time, want.tgt, got.tgt);
        if (got.dir !== want.dir)
          $display("%0t: direction_out exp %0b got %0b", $time, want.dir, got.dir);
        if (got.chg !== want.chg)
          $display("%0t: direction_changed exp %0b got %0b", $time, want.chg, got.chg);
        if (got !== want) errors++;
      end
    end
  end

  // watchdog: cycles with no transfer on any port
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    row_t rows[$];
    loop_out_t got;
    m_kp = 8'd1; m_ki = 8'd1; m_kd = 8'd0; m_sp = pidsp_pkg::SP_RESET;
    m_integ = '0; m_prev_err = '0; m_last_push = 1'b0; m_dir = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // after reset: setpoint 127 holds, speed 744 matched exactly gives duty 127
    rows.push_back('{'{pidsp_pkg::ENC_NONE, 2'd0, 1'b0, 1'b0, 16'd744}, 1'b1,
                     '{8'd127, 8'd127, 10'd744, 1'b0, 1'b0}});
    rows.push_back('{'{pidsp_pkg::ENC_UP, 2'd0, 1'b0, 1'b1, 16'd0}, 1'b0, '0});
    rows.push_back('{'{pidsp_pkg::ENC_DOWN, 2'd1, 1'b0, 1'b1, 16'hFFFF}, 1'b0, '0});
    rows.push_back('{'{pidsp_pkg::ENC_DOWN2, 2'd2, 1'b0, 1'b0, 16'd500}, 1'b0, '0});
    rows.push_back('{'{pidsp_pkg::ENC_UP, 2'd3, 1'b0, 1'b0, 16'd1012}, 1'b0, '0});
    rows.push_back('{'{pidsp_pkg::ENC_UP, 2'd3, 1'b1, 1'b0, 16'd0}, 1'b0, '0});
    // setpoint cleared by stop: going down saturates at zero
    rows.push_back('{'{pidsp_pkg::ENC_DOWN2, 2'd3, 1'b0, 1'b0, 16'd0}, 1'b0, '0});
    rows.push_back('{'{pidsp_pkg::ENC_DOWN, 2'd0, 1'b0, 1'b1, 16'hAAAA}, 1'b0, '0});
    for (int i = 0; i < 28; i++)
      rows.push_back('{'{pidsp_pkg::ENC_UP, 2'd2, 1'b0, 1'b1, 16'h5555}, 1'b0, '0});
    foreach (rows[i]) begin
      send_tick(rows[i].t, 1'b0);
      if (rows[i].known) begin
        got = duty_q[duty_q.size() - 1];
        if (got !== rows[i].res) begin
          $display("%0t: directed row %0d exp %p got %p", $time, i, rows[i].res, got);
          errors++;
        end
      end
    end
    drain();

    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: begin write_gain(pidsp_pkg::REG_PROP, 8'd255); write_gain(pidsp_pkg::REG_INTEG, 8'd255);
                 write_gain(pidsp_pkg::REG_DERIV, 8'd255); end
        1: begin write_gain(pidsp_pkg::REG_PROP, 8'd0); write_gain(pidsp_pkg::REG_INTEG, 8'd0);
                 write_gain(pidsp_pkg::REG_DERIV, 8'd0); end
        2: begin write_gain(2'd3, 8'hFF); write_gain(pidsp_pkg::REG_PROP, 8'd2);
                 write_gain(pidsp_pkg::REG_INTEG, 8'd1); write_gain(pidsp_pkg::REG_DERIV, 8'd1); end
        3: for (int k = 0; k < 3; k++) write_gain(k[1:0], 8'($urandom));
        default: begin write_gain(pidsp_pkg::REG_PROP, 8'd1); write_gain(pidsp_pkg::REG_INTEG, 8'd1);
                       write_gain(pidsp_pkg::REG_DERIV, 8'd0); end
      endcase
      if (phase == 1) begin
        // receiver holds off while ticks keep coming
        fork
          begin
            hold_off = 1'b1;
            repeat (1500) @(posedge clk);
            hold_off = 1'b0;
          end
          for (int n = 0; n < 6; n++) send_tick(rand_tick(), 1'b0);
        join
      end
      if (phase == 4) quiet = 1'b1;
      for (int n = 0; n < 180; n++) send_tick(rand_tick(), 1'b1);
      drain();
    end

    if (errors == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end
endmodule
`default_nettype wire

[sim.f]
+incdir+hw/rtl
hw/rtl/pidsp_pkg.sv
hw/rtl/pidsp_div.sv
hw/rtl/pidsp_dp.sv
hw/rtl/pidsp_ctrl.sv
hw/rtl/pid_speed_loop_with_rpm_table.sv
tb/pid_speed_loop_with_rpm_table_tb.sv
